FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/smfp_pkg.sv
// ----------------------------------------------------------------------------
// smfp_pkg
// Types and codes shared by the signed message frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package smfp_pkg;

  localparam logic [3:0] SEC_DEST    = 4'd0;
  localparam logic [3:0] SEC_SRC     = 4'd1;
  localparam logic [3:0] SEC_SIG     = 4'd2;
  localparam logic [3:0] SEC_ARR     = 4'd3;
  localparam logic [3:0] SEC_TIME    = 4'd4;
  localparam logic [3:0] SEC_TITLE   = 4'd5;
  localparam logic [3:0] SEC_CONTENT = 4'd6;
  localparam logic [3:0] SEC_FIELDS  = 4'd7;
  localparam logic [3:0] SEC_STAMP   = 4'd8;
  localparam logic [3:0] SEC_IGN     = 4'd9;

  localparam logic [3:0] ERR_NONE    = 4'd0;
  localparam logic [3:0] ERR_SHORT   = 4'd1;
  localparam logic [3:0] ERR_ARR     = 4'd2;
  localparam logic [3:0] ERR_TIME    = 4'd3;
  localparam logic [3:0] ERR_TITLE   = 4'd4;
  localparam logic [3:0] ERR_CONTENT = 4'd5;
  localparam logic [3:0] ERR_FIELDS  = 4'd6;
  localparam logic [3:0] ERR_DEPTH   = 4'd7;
  localparam logic [3:0] ERR_TRUNC   = 4'd8;

  localparam logic [7:0] HASH_ARR_HDR = 8'h94;
  localparam logic [7:0] TAG_F64      = 8'hCB;
  localparam logic [7:0] TAG_STR8     = 8'hD9;
  localparam logic [7:0] TAG_STR16    = 8'hDA;
  localparam logic [7:0] TAG_BIN8     = 8'hC4;
  localparam logic [7:0] TAG_BIN16    = 8'hC5;
  localparam logic [6:0] HDR_BYTES    = 7'd96;

  localparam int BL_W  = 17;
  localparam int OUT_W = 24;

  typedef enum logic [14:0] {
    PH_DEST      = 15'h0001,
    PH_SRC       = 15'h0002,
    PH_SIG       = 15'h0004,
    PH_ARR       = 15'h0008,
    PH_TIME_HDR  = 15'h0010,
    PH_TIME      = 15'h0020,
    PH_TITLE_HDR = 15'h0040,
    PH_TITLE     = 15'h0080,
    PH_CONT_HDR  = 15'h0100,
    PH_CONT      = 15'h0200,
    PH_FIELDS    = 15'h0400,
    PH_STAMP_HDR = 15'h0800,
    PH_STAMP     = 15'h1000,
    PH_DONE      = 15'h2000,
    PH_DEAD      = 15'h4000
  } phase_t;

  typedef struct packed {
    logic [BL_W-1:0] bl;
    logic [1:0]      lbl;
    logic [3:0]      err;
    logic            done;
  } fields_res_t;

endpackage

`default_nettype wire

FILE: src/smfp_fields.sv
// ----------------------------------------------------------------------------
// smfp_fields
// Skip logic for the nested fields value: one byte, next counters and stack.
// ----------------------------------------------------------------------------
`default_nettype none

module smfp_fields
  import smfp_pkg::*;
#(
  parameter int MAX_DEPTH = 8,
  parameter int LW = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic [7:0]      b,
  input  wire logic [BL_W-1:0] bl,
  input  wire logic [1:0]      lbl,
  input  wire logic [LW-1:0]   lv,
  input  wire logic [4:0]      cnt [MAX_DEPTH],
  output fields_res_t          res,
  output logic      [LW-1:0]   lv_next,
  output logic      [4:0]      cnt_next [MAX_DEPTH]
);

  logic          do_dec;
  logic          do_push;
  logic          do_done;
  logic [4:0]    c;
  logic [LW-1:0] lv_mid;
  logic [LW-1:0] top;

  always_comb begin
    res.bl   = bl;
    res.lbl  = lbl;
    res.err  = ERR_NONE;
    do_dec   = 1'b0;
    do_push  = 1'b0;
    do_done  = 1'b0;
    c        = b[4] ? {1'b0, b[3:0]} : {b[3:0], 1'b0};
    if (lbl != 2'd0) begin
      res.bl  = {bl[8:0], b};
      res.lbl = lbl - 2'd1;
      do_done = (res.lbl == 2'd0) && ({bl[8:0], b} == '0);
    end else if (bl != '0) begin
      res.bl  = bl - BL_W'(1);
      do_done = (res.bl == '0);
    end else if (b[7:5] == 3'b101) begin
      do_dec  = 1'b1;
      res.bl  = {{(BL_W-5){1'b0}}, b[4:0]};
      do_done = (b[4:0] == 5'd0);
    end else if (b[7:5] == 3'b100) begin
      if (c != 5'd0 && lv >= LW'(MAX_DEPTH)) begin
        res.err = ERR_DEPTH;
      end else begin
        do_dec = 1'b1;
        if (c == 5'd0) do_done = 1'b1;
        else do_push = 1'b1;
      end
    end else if (!b[7] || b >= 8'hE0 || b == 8'hC0 || b == 8'hC2 || b == 8'hC3) begin
      do_dec  = 1'b1;
      do_done = 1'b1;
    end else begin
      do_dec = 1'b1;
      case (b)
        8'hCC, 8'hD0:        res.bl = BL_W'(1);
        8'hCD, 8'hD1:        res.bl = BL_W'(2);
        8'hCE, 8'hD2, 8'hCA: res.bl = BL_W'(4);
        8'hCF, 8'hD3, 8'hCB: res.bl = BL_W'(8);
        8'hD9, 8'hC4:        res.lbl = 2'd1;
        8'hDA, 8'hC5:        res.lbl = 2'd2;
        default: begin
          res.err = ERR_FIELDS;
          do_dec  = 1'b0;
        end
      endcase
    end

    for (int j = 0; j < MAX_DEPTH; j++) begin
      cnt_next[j] = cnt[j];
      if (do_dec && lv != '0 && LW'(j + 1) == lv) cnt_next[j] = cnt[j] - 5'd1;
      if (do_push && LW'(j) == lv) cnt_next[j] = c;
    end
    lv_mid = do_push ? lv + LW'(1) : lv;

    top = '0;
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if (LW'(j) < lv_mid && cnt_next[j] != 5'd0) top = LW'(j + 1);
    end
    lv_next  = do_done ? top : lv_mid;
    res.done = do_done && (top == '0);
  end

endmodule

`default_nettype wire

FILE: src/signed_message_frame_parser.sv
// Each accepted input item's result is registered and offered in the next cycle.
// Throughput: one item per cycle while the receiver keeps taking results; the result register frees as it is taken.
// Reset: rst (sync, high) clears the parse state and empties the result register.
// The parse state also returns to its reset values after each frame's last item.
// ----------------------------------------------------------------------------
// signed_message_frame_parser
// Per-byte section, hash and payload tagging with end-of-frame status.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_message_frame_parser
  import smfp_pkg::*;
#(
  parameter int MAX_DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,  // frame_byte
  input  wire logic             s_axis_tlast,  // frame_last
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // out_byte[7:0] section[11:8] in_hash[12] is_payload[13] frame_ok[14]
  // error_code[18:15] stamp_valid[19], zero fill to 24
  output logic [OUT_W-1:0]      m_axis_tdata,
  output logic                  m_axis_tlast   // frame_end
);

  localparam int LW = $clog2(MAX_DEPTH + 1);

  phase_t          ph, ph_next;
  logic [6:0]      hc, hc_next;
  logic [3:0]      et, et_next;
  logic [BL_W-1:0] bl, bl_next;
  logic [1:0]      lbl, lbl_next;
  logic [LW-1:0]   lv, lv_next;
  logic [4:0]      cnt [MAX_DEPTH];
  logic [4:0]      cnt_next [MAX_DEPTH];
  logic [3:0]      es, es_next;
  logic            sd, sd_next;

  fields_res_t     fr;
  logic [LW-1:0]   f_lv;
  logic [4:0]      f_cnt [MAX_DEPTH];

  logic            acc;
  logic [7:0]      b;
  logic [7:0]      ob;
  logic [3:0]      sec, err, code;
  logic            hash, pay, ok, sv;
  logic            tag_ok, str_end;
  logic [BL_W-1:0] tbl;
  logic [1:0]      tlbl;
  phase_t          fin_ph;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  smfp_fields #(.MAX_DEPTH(MAX_DEPTH), .LW(LW)) u_fields (
    .b        (b),
    .bl       (bl),
    .lbl      (lbl),
    .lv       (lv),
    .cnt      (cnt),
    .res      (fr),
    .lv_next  (f_lv),
    .cnt_next (f_cnt)
  );

  always_comb begin
    tag_ok = 1'b1;
    tbl    = '0;
    tlbl   = 2'd0;
    if (b[7:5] == 3'b101) tbl = {{(BL_W-5){1'b0}}, b[4:0]};
    else if (b == TAG_STR8 || b == TAG_BIN8) tlbl = 2'd1;
    else if (b == TAG_STR16 || b == TAG_BIN16) tlbl = 2'd2;
    else tag_ok = 1'b0;
  end

  always_comb begin
    ph_next  = ph;
    hc_next  = hc;
    et_next  = et;
    bl_next  = bl;
    lbl_next = lbl;
    lv_next  = lv;
    cnt_next = cnt;
    es_next  = es;
    sd_next  = sd;
    ob       = b;
    sec      = SEC_IGN;
    err      = ERR_NONE;
    hash     = 1'b0;
    pay      = 1'b0;
    str_end  = 1'b0;

    case (ph)
      PH_TITLE_HDR, PH_TITLE: fin_ph = PH_CONT_HDR;
      PH_CONT_HDR, PH_CONT:   fin_ph = (et >= 4'd4) ? PH_FIELDS : PH_DONE;
      default:                fin_ph = PH_DONE;
    endcase

    case (ph)
      PH_DEST, PH_SRC, PH_SIG: begin
        sec     = (ph == PH_DEST) ? SEC_DEST : ((ph == PH_SRC) ? SEC_SRC : SEC_SIG);
        hash    = (ph != PH_SIG);
        hc_next = hc + 7'd1;
        if (hc_next >= HDR_BYTES) ph_next = PH_ARR;
        else if (hc_next >= 7'd32) ph_next = PH_SIG;
        else if (hc_next >= 7'd16) ph_next = PH_SRC;
      end
      PH_ARR: begin
        sec = SEC_ARR;
        if (b[7:4] == 4'h9 && b[3:0] >= 4'd3) begin
          et_next = b[3:0];
          ob      = HASH_ARR_HDR;
          hash    = 1'b1;
          ph_next = PH_TIME_HDR;
        end else begin
          err = ERR_ARR;
        end
      end
      PH_TIME_HDR: begin
        sec = SEC_TIME;
        if (b == TAG_F64) begin
          bl_next = BL_W'(8);
          hash    = 1'b1;
          ph_next = PH_TIME;
        end else begin
          err = ERR_TIME;
        end
      end
      PH_TIME: begin
        sec     = SEC_TIME;
        hash    = 1'b1;
        pay     = 1'b1;
        bl_next = (bl != '0) ? bl - BL_W'(1) : bl;
        if (bl_next == '0) ph_next = PH_TITLE_HDR;
      end
      PH_TITLE_HDR, PH_CONT_HDR, PH_STAMP_HDR: begin
        sec = (ph == PH_TITLE_HDR) ? SEC_TITLE :
              ((ph == PH_CONT_HDR) ? SEC_CONTENT : SEC_STAMP);
        bl_next  = tbl;
        lbl_next = tlbl;
        if (!tag_ok) begin
          if (ph == PH_STAMP_HDR) ph_next = PH_DONE;
          else err = (ph == PH_TITLE_HDR) ? ERR_TITLE : ERR_CONTENT;
        end else begin
          hash = (ph != PH_STAMP_HDR);
          if (tbl == '0 && tlbl == 2'd0) str_end = 1'b1;
          else ph_next = (ph == PH_TITLE_HDR) ? PH_TITLE :
                         ((ph == PH_CONT_HDR) ? PH_CONT : PH_STAMP);
        end
      end
      PH_TITLE, PH_CONT, PH_STAMP: begin
        sec = (ph == PH_TITLE) ? SEC_TITLE : ((ph == PH_CONT) ? SEC_CONTENT : SEC_STAMP);
        hash = (ph != PH_STAMP);
        if (lbl != 2'd0) begin
          bl_next  = {bl[8:0], b};
          lbl_next = lbl - 2'd1;
          str_end  = (lbl_next == 2'd0) && (bl_next == '0);
        end else begin
          pay     = 1'b1;
          bl_next = (bl != '0) ? bl - BL_W'(1) : bl;
          str_end = (bl_next == '0);
        end
      end
      PH_FIELDS: begin
        sec      = SEC_FIELDS;
        err      = fr.err;
        hash     = (fr.err == ERR_NONE);
        bl_next  = fr.bl;
        lbl_next = fr.lbl;
        lv_next  = f_lv;
        cnt_next = f_cnt;
        if (fr.done) ph_next = (et >= 4'd5) ? PH_STAMP_HDR : PH_DONE;
      end
      default: begin
      end
    endcase

    if (str_end) begin
      ph_next = fin_ph;
      if (ph == PH_STAMP_HDR || ph == PH_STAMP) sd_next = 1'b1;
    end

    if (err != ERR_NONE) begin
      hash    = 1'b0;
      pay     = 1'b0;
      ph_next = PH_DEAD;
      if (es == ERR_NONE) es_next = err;
    end

    code = es_next;
    if (code == ERR_NONE) begin
      case (ph_next)
        PH_DEST, PH_SRC, PH_SIG, PH_ARR: code = ERR_SHORT;
        PH_TIME_HDR, PH_TIME, PH_TITLE_HDR, PH_TITLE, PH_CONT_HDR, PH_CONT: code = ERR_TRUNC;
        PH_FIELDS: if (lv_next != '0 || bl_next != '0 || lbl_next != 2'd0) code = ERR_TRUNC;
        default: begin
        end
      endcase
    end
    ok = (code == ERR_NONE);
    sv = ok && sd_next;
    if (!s_axis_tlast) begin
      code = ERR_NONE;
      ok   = 1'b0;
      sv   = 1'b0;
    end else begin
      ph_next  = PH_DEST;
      hc_next  = '0;
      et_next  = '0;
      bl_next  = '0;
      lbl_next = '0;
      lv_next  = '0;
      for (int j = 0; j < MAX_DEPTH; j++) cnt_next[j] = '0;
      es_next  = ERR_NONE;
      sd_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph  <= PH_DEST;
      hc  <= '0;
      et  <= '0;
      bl  <= '0;
      lbl <= '0;
      lv  <= '0;
      for (int j = 0; j < MAX_DEPTH; j++) cnt[j] <= '0;
      es  <= ERR_NONE;
      sd  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (acc) begin
        ph  <= ph_next;
        hc  <= hc_next;
        et  <= et_next;
        bl  <= bl_next;
        lbl <= lbl_next;
        lv  <= lv_next;
        cnt <= cnt_next;
        es  <= es_next;
        sd  <= sd_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      m_axis_tdata <= {4'd0, sv, code, ok, pay, hash, sec, ob};
      m_axis_tlast <= s_axis_tlast;
    end
  end

endmodule

`default_nettype wire

FILE: src/smfp_checker.sv
// ----------------------------------------------------------------------------
// smfp_checker
// Port-level checks on the frame parser's result stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module smfp_checker
  import smfp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tlast
);

  logic held;
  assign held = m_axis_tvalid && !m_axis_tready;

  `ASSERT_NXT(a_hold, clk, rst, held, m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMP(a_status_only_at_end, clk, rst, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[19:14] == 6'd0)
  `ASSERT_IMP(a_ok_iff_no_code, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[14] == (m_axis_tdata[18:15] == ERR_NONE))
  `ASSERT_IMP(a_stamp_needs_ok, clk, rst, m_axis_tvalid && m_axis_tdata[19], m_axis_tdata[14])

endmodule

bind signed_message_frame_parser smfp_checker u_smfp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: sim/tb_signed_message_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_message_frame_parser
// Streams whole frames (well-formed, truncated, corrupted and short) byte by
// byte through the parser under random sender bursts and receiver stalls. A
// scoreboard class predicts every result item and checks it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_signed_message_frame_parser;
  import smfp_pkg::*;

  localparam int DEPTH_MAX = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int ITEM_GOAL = 1650;

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [3:0] {
    S_DEST, S_SRC, S_SIG, S_ARR, S_TIME_TAG, S_TIME, S_TITLE_TAG, S_TITLE,
    S_CONT_TAG, S_CONT, S_FIELDS, S_STAMP_TAG, S_STAMP, S_DONE, S_DEAD
  } parse_state_t;

  class frame_scoreboard;
    logic [OUT_W-1:0] want_q[$];
    logic want_end_q[$];
    int fails;
    int frames;
    int code_hits[9];
    int stamps;
    int hdr_cnt;
    parse_state_t st;
    int elems;
    int left;
    int len_left;
    int skip[DEPTH_MAX];
    int lvl;
    logic [3:0] err_seen;
    bit stamp_done;

    function new();
      clear();
    endfunction

    function void clear();
      hdr_cnt = 0;
      st = S_DEST;
      elems = 0;
      left = 0;
      len_left = 0;
      foreach (skip[i]) skip[i] = 0;
      lvl = 0;
      err_seen = ERR_NONE;
      stamp_done = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function bit str_tag(logic [7:0] b);
      if (b[7:5] == 3'b101) begin
        left = b[4:0];
        len_left = 0;
        return 1;
      end
      left = 0;
      if (b == TAG_STR8 || b == TAG_BIN8) begin
        len_left = 1;
        return 1;
      end
      if (b == TAG_STR16 || b == TAG_BIN16) begin
        len_left = 2;
        return 1;
      end
      len_left = 0;
      return 0;
    endfunction

    function bit str_data(logic [7:0] b, output bit pay);
      pay = 0;
      if (len_left > 0) begin
        left = ((left << 8) | b) & 'h1FFFF;
        len_left--;
        return len_left == 0 && left == 0;
      end
      pay = 1;
      if (left > 0) left--;
      return left == 0;
    endfunction

    function void value_done();
      while (lvl > 0 && skip[lvl-1] == 0) lvl--;
      if (lvl == 0) st = (elems >= 5) ? S_STAMP_TAG : S_DONE;
    endfunction

    function logic [3:0] fields_byte(logic [7:0] b);
      int c;
      if (len_left > 0) begin
        left = ((left << 8) | b) & 'h1FFFF;
        len_left--;
        if (len_left == 0 && left == 0) value_done();
        return ERR_NONE;
      end
      if (left > 0) begin
        left--;
        if (left == 0) value_done();
        return ERR_NONE;
      end
      if (b[7:5] == 3'b101) begin
        if (lvl > 0) skip[lvl-1]--;
        left = b[4:0];
        if (left == 0) value_done();
        return ERR_NONE;
      end
      if (b[7:5] == 3'b100) begin
        c = b[3:0] * ((b[7:4] == 4'h8) ? 2 : 1);
        if (c != 0 && lvl >= DEPTH_MAX) return ERR_DEPTH;
        if (lvl > 0) skip[lvl-1]--;
        if (c == 0) begin
          value_done();
          return ERR_NONE;
        end
        skip[lvl] = c;
        lvl++;
        return ERR_NONE;
      end
      if (b < 8'h80 || b >= 8'hE0 || b == 8'hC0 || b == 8'hC2 || b == 8'hC3) begin
        if (lvl > 0) skip[lvl-1]--;
        value_done();
        return ERR_NONE;
      end
      case (b)
        8'hCC, 8'hD0: left = 1;
        8'hCD, 8'hD1: left = 2;
        8'hCE, 8'hD2, 8'hCA: left = 4;
        8'hCF, 8'hD3, 8'hCB: left = 8;
        8'hD9, 8'hC4: len_left = 1;
        8'hDA, 8'hC5: len_left = 2;
        default: return ERR_FIELDS;
      endcase
      if (lvl > 0) skip[lvl-1]--;
      return ERR_NONE;
    endfunction

    function void note_item(logic [7:0] b, bit last);
      logic [7:0] ob;
      logic [3:0] sec, err, code;
      bit hash, pay, stamp, fin;
      ob = b;
      sec = SEC_IGN;
      err = ERR_NONE;
      hash = 0;
      pay = 0;
      code = ERR_NONE;
      case (st)
        S_DEST, S_SRC, S_SIG: begin
          sec = 4'(st);
          hash = st != S_SIG;
          hdr_cnt++;
          if (hdr_cnt >= 96) st = S_ARR;
          else if (hdr_cnt >= 32) st = S_SIG;
          else if (hdr_cnt >= 16) st = S_SRC;
        end
        S_ARR: begin
          sec = SEC_ARR;
          if (b[7:4] == 4'h9 && b[3:0] >= 3) begin
            elems = b[3:0];
            ob = HASH_ARR_HDR;
            hash = 1;
            st = S_TIME_TAG;
          end else err = ERR_ARR;
        end
        S_TIME_TAG: begin
          sec = SEC_TIME;
          if (b == TAG_F64) begin
            left = 8;
            hash = 1;
            st = S_TIME;
          end else err = ERR_TIME;
        end
        S_TIME: begin
          sec = SEC_TIME;
          hash = 1;
          pay = 1;
          if (left > 0) left--;
          if (left == 0) st = S_TITLE_TAG;
        end
        S_TITLE_TAG, S_CONT_TAG, S_STAMP_TAG: begin
          stamp = st == S_STAMP_TAG;
          sec = stamp ? SEC_STAMP : (st == S_TITLE_TAG ? SEC_TITLE : SEC_CONTENT);
          if (!str_tag(b)) begin
            if (stamp) st = S_DONE;
            else err = (sec == SEC_TITLE) ? ERR_TITLE : ERR_CONTENT;
          end else begin
            hash = !stamp;
            if (len_left == 0 && left == 0) begin
              if (sec == SEC_TITLE) st = S_CONT_TAG;
              else if (sec == SEC_CONTENT) st = (elems >= 4) ? S_FIELDS : S_DONE;
              else begin
                stamp_done = 1;
                st = S_DONE;
              end
            end else begin
              st = (st == S_TITLE_TAG) ? S_TITLE : (st == S_CONT_TAG ? S_CONT : S_STAMP);
            end
          end
        end
        S_TITLE, S_CONT, S_STAMP: begin
          sec = (st == S_TITLE) ? SEC_TITLE : (st == S_CONT ? SEC_CONTENT : SEC_STAMP);
          hash = sec != SEC_STAMP;
          fin = str_data(b, pay);
          if (fin) begin
            if (sec == SEC_TITLE) st = S_CONT_TAG;
            else if (sec == SEC_CONTENT) st = (elems >= 4) ? S_FIELDS : S_DONE;
            else begin
              stamp_done = 1;
              st = S_DONE;
            end
          end
        end
        S_FIELDS: begin
          sec = SEC_FIELDS;
          err = fields_byte(b);
          hash = err == ERR_NONE;
        end
        default: ;
      endcase
      if (err != ERR_NONE) begin
        hash = 0;
        pay = 0;
        if (err_seen == ERR_NONE) err_seen = err;
        st = S_DEAD;
      end
      if (last) begin
        code = err_seen;
        if (code == ERR_NONE) begin
          if (st <= S_ARR) code = ERR_SHORT;
          else if (st <= S_CONT) code = ERR_TRUNC;
          else if (st == S_FIELDS && (lvl > 0 || left > 0 || len_left > 0))
            code = ERR_TRUNC;
        end
        frames++;
        code_hits[code]++;
        if (code == ERR_NONE && stamp_done) stamps++;
      end
      want_q.insert(want_q.size(), {4'b0, last && code == ERR_NONE && stamp_done, code,
                                    last && code == ERR_NONE, pay, hash, sec, ob});
      want_end_q.insert(want_end_q.size(), last);
      if (last) clear();
    endfunction

    function void check_result(logic [OUT_W-1:0] got, logic got_end);
      logic [OUT_W-1:0] want;
      logic want_end;
      string nm[8] = '{"out_byte", "section", "in_hash", "is_payload", "frame_ok",
                       "error_code", "stamp_valid", "frame_end"};
      int lo[8] = '{0, 8, 12, 13, 14, 15, 19, 0};
      int w[8] = '{8, 4, 1, 1, 1, 4, 1, 1};
      int a, e;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected item %h", $time, got);
        fails++;
        return;
      end
      want = want_q.pop_front();
      want_end = want_end_q.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (i == 7) begin
          a = got_end;
          e = want_end;
        end else begin
          a = (got >> lo[i]) & ((1 << w[i]) - 1);
          e = (want >> lo[i]) & ((1 << w[i]) - 1);
        end
        if (a !== e) begin
          $display("%0t: %s mismatch expected %0h actual %0h", $time, nm[i], e, a);
          fails++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  frame_scoreboard sb = new();
  int sent;
  int burst_left;
  int hold_req_n;
  int hold_seen_n;
  int hold_cnt;
  int stall_mode;
  int mode_cnt;
  int idle_cnt;

  signed_message_frame_parser #(.MAX_DEPTH(DEPTH_MAX)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: stall pattern plus requested long hold-offs
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if (hold_req_n != hold_seen_n) begin
        hold_seen_n = hold_req_n;
        hold_cnt = 300;
      end
      mode_cnt++;
      if (mode_cnt >= 100) begin
        mode_cnt = 0;
        stall_mode = $urandom_range(0, 2);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (stall_mode == 0) m_axis_tready <= 1'b1;
      else if (stall_mode == 1) m_axis_tready <= 1'($urandom_range(0, 1));
      else m_axis_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d items outstanding", $time, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(b, last);
    burst_left--;
    sent++;
  endtask

  task automatic send_frame(byte_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic add_byte(ref byte_q_t f, input logic [7:0] v);
    f.insert(f.size(), v);
  endtask

  task automatic add_header(ref byte_q_t f);
    repeat (96) add_byte(f, 8'($urandom_range(0, 255)));
  endtask

  task automatic add_time(ref byte_q_t f);
    add_byte(f, TAG_F64);
    repeat (8) add_byte(f, 8'($urandom_range(0, 255)));
  endtask

  task automatic add_str(ref byte_q_t f, input int len);
    int form;
    form = $urandom_range((len < 32) ? 0 : 1, 4);
    case (form)
      0: add_byte(f, 8'hA0 | len[4:0]);
      1, 3: begin
        add_byte(f, form == 1 ? TAG_STR8 : TAG_BIN8);
        add_byte(f, len[7:0]);
      end
      default: begin
        add_byte(f, form == 2 ? TAG_STR16 : TAG_BIN16);
        add_byte(f, len[15:8]);
        add_byte(f, len[7:0]);
      end
    endcase
    repeat (len) add_byte(f, 8'($urandom_range(0, 255)));
  endtask

  task automatic add_value(ref byte_q_t f, input int lvl, input bit noisy);
    int n, k;
    if (lvl < 9 && $urandom_range(0, lvl + 1) == 0) begin
      n = $urandom_range(0, 3);
      k = $urandom_range(0, 1);
      add_byte(f, k ? (8'h80 | n[3:0]) : (8'h90 | n[3:0]));
      repeat (k ? 2 * n : n) add_value(f, lvl + 1, noisy);
    end else if (noisy && $urandom_range(0, 19) == 0) begin
      add_byte(f, 8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 9))
        0: add_byte(f, 8'($urandom_range(0, 8'h7F)));
        1: add_byte(f, 8'($urandom_range(8'hE0, 8'hFF)));
        2: add_byte(f, 8'hC0 | ($urandom_range(0, 1) ? 8'h02 : 8'h03));
        3: begin add_byte(f, 8'hCC); add_byte(f, 8'($urandom_range(0, 255))); end
        4: begin add_byte(f, 8'hD1); repeat (2) add_byte(f, 8'($urandom_range(0, 255))); end
        5: begin add_byte(f, 8'hCA); repeat (4) add_byte(f, 8'($urandom_range(0, 255))); end
        6: begin add_byte(f, 8'hD3); repeat (8) add_byte(f, 8'($urandom_range(0, 255))); end
        7: add_byte(f, 8'hC0);
        default: add_str(f, $urandom_range(0, 6));
      endcase
    end
  endtask

  task automatic build_good(ref byte_q_t f, input int n, input bit noisy);
    add_header(f);
    add_byte(f, 8'h90 | n[3:0]);
    add_time(f);
    add_str(f, $urandom_range(0, 4) == 0 ? $urandom_range(32, 40) : $urandom_range(0, 8));
    add_str(f, $urandom_range(0, 12));
    if (n >= 4) add_value(f, 0, noisy);
    if (n >= 5) add_str(f, $urandom_range(0, 6));
    if (n > 5) repeat ($urandom_range(0, 4)) add_byte(f, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    byte_q_t f;
    int n;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    sent = 0;
    burst_left = 0;
    hold_req_n = 0;
    hold_seen_n = 0;
    hold_cnt = 0;
    stall_mode = 0;
    mode_cnt = 0;
    idle_cnt = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // long receiver hold-off while the sender keeps offering
    hold_req_n++;

    // directed frames
    f = {}; build_good(f, 4, 0); f[96] = 8'h92; send_frame(f);
    f = {}; build_good(f, 4, 0); f[97] = 8'hCA; send_frame(f);
    f = {}; build_good(f, 4, 0); f[106] = 8'hC6; send_frame(f);
    f = {}; add_header(f); add_byte(f, 8'h93); add_time(f);
    add_byte(f, 8'hA0); add_byte(f, 8'hDB); send_frame(f);
    f = {}; add_header(f); add_byte(f, 8'h94); add_time(f);
    add_byte(f, 8'hA0); add_byte(f, 8'hA0); add_byte(f, 8'hC1); send_frame(f);
    // nine nested arrays: ninth open exceeds the depth bound
    f = {}; add_header(f); add_byte(f, 8'h94); add_time(f);
    add_byte(f, 8'hA0); add_byte(f, 8'hA0);
    repeat (9) add_byte(f, 8'h91); add_byte(f, 8'h01); send_frame(f);
    // eight nested arrays then an empty one at the bound: ok
    f = {}; add_header(f); add_byte(f, 8'h94); add_time(f);
    add_byte(f, 8'hA0); add_byte(f, 8'hA0);
    repeat (8) add_byte(f, 8'h91); add_byte(f, 8'h90); send_frame(f);
    f = {}; add_header(f); add_byte(f, 8'h94); add_time(f);
    add_byte(f, 8'hA0); add_byte(f, 8'hA0); add_byte(f, 8'h82); add_byte(f, 8'h01);
    send_frame(f);
    f = {}; add_header(f); add_byte(f, 8'h95); add_time(f);
    add_byte(f, 8'hA0); add_byte(f, 8'hA0); add_byte(f, 8'hC0); add_byte(f, 8'h91);
    add_byte(f, 8'h00); send_frame(f);
    f = {}; add_header(f); add_byte(f, 8'h95); add_time(f);
    add_byte(f, 8'hA1); add_byte(f, 8'h41); add_byte(f, 8'hA0); add_byte(f, 8'hC0);
    add_byte(f, 8'hDA); add_byte(f, 8'h00); send_frame(f);
    f = {}; add_header(f); add_byte(f, 8'h94); add_time(f);
    add_str(f, 2); add_str(f, 3); send_frame(f);
    f = {}; repeat (50) add_byte(f, 8'($urandom_range(0, 255))); send_frame(f);
    f = {}; add_header(f); send_frame(f);
    f = {}; add_byte(f, 8'hFF); send_frame(f);
    f = {}; add_header(f); add_byte(f, 8'h93); add_byte(f, TAG_F64); add_byte(f, 8'h00);
    send_frame(f);
    drain();

    // random frames
    n = 0;
    while (sent < ITEM_GOAL) begin
      f = {};
      build_good(f, ($urandom_range(0, 5) == 0) ? $urandom_range(6, 15)
                                                : $urandom_range(3, 5), 1);
      case ($urandom_range(0, 9))
        0, 1: f = f[0 : $urandom_range(0, f.size() - 2)];
        2, 3: f[$urandom_range(96, f.size() - 1)] = 8'($urandom_range(0, 255));
        4: f = f[0 : $urandom_range(0, 110)];
        default: ;
      endcase
      send_frame(f);
      if (n % 7 == 6) drain();
      n++;
    end
    drain();
    repeat (10) @(posedge clk);

    $display("%0d items in %0d frames, %0d ok with stamp", sent, sb.frames, sb.stamps);
    $display("frame status counts (none..truncated): %p", sb.code_hits);
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
